/* design/psd_pkg.sv */
// Shared types and constants for the charge comparison PSD core.
package psd_pkg;

  // Register indexes of the configuration port
  typedef enum logic [7:0] {
    REG_POLARITY   = 8'd0,
    REG_GATE_START = 8'd1,
    REG_SHORT_LEN  = 8'd2,
    REG_LONG_LEN   = 8'd3
  } psd_reg_e;

  // Register reset values
  localparam logic        POLARITY_RST   = 1'b0;
  localparam logic [15:0] GATE_START_RST = 16'd110;
  localparam logic [15:0] SHORT_LEN_RST  = 16'd30;
  localparam logic [15:0] LONG_LEN_RST   = 16'd90;

  // Sample index width: wide enough for the widest gate end (gate start plus gate length)
  localparam int IDX_W = 17;
  // Baseline in 1/64 units and the widths of the charge products
  localparam int B64_W  = 22;
  localparam int PROD_W = 38;

  typedef struct packed {
    logic [15:0] sample;
    logic        last_sample;
    logic [63:0] time_stamp;
    logic [7:0]  chan;
  } psd_in_t;

  typedef struct packed {
    logic [63:0] event_time;
    logic [7:0]  event_channel;
    logic [15:0] short_charge;
    logic [15:0] long_charge;
    logic [15:0] baseline_level;
  } psd_out_t;

  typedef struct packed {
    logic        positive_polarity;
    logic [15:0] gate_start;
    logic [15:0] short_gate_length;
    logic [15:0] long_gate_length;
  } psd_cfg_t;

  // Waveform summary handed from front to back (baseline sum travels apart)
  typedef struct packed {
    logic [63:0] time_stamp;
    logic [7:0]  chan;
    logic        positive_polarity;
    logic [31:0] short_sum;
    logic [15:0] short_count;
    logic [31:0] long_sum;
    logic [15:0] long_count;
  } psd_evt_t;

endpackage

/* design/psd_front.sv */
// Front end: accumulates baseline and gate sums per waveform, queues a summary on the last beat.
module psd_front #(
  parameter int BASE = 64,
  parameter int BW   = 22
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psd_pkg::psd_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psd_pkg::psd_in_t  in_i,
  input  logic              full_i,
  output logic              push_o,
  output psd_pkg::psd_evt_t evt_o,
  output logic [BW-1:0]     bsum_o
);
  import psd_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [BW-1:0]    bsum_q, bsum_d, bsum_nx;
  logic [31:0]      ssum_q, ssum_d, ssum_nx;
  logic [31:0]      lsum_q, lsum_d, lsum_nx;
  logic [15:0]      scnt_q, scnt_d, scnt_nx;
  logic [15:0]      lcnt_q, lcnt_d, lcnt_nx;
  logic [IDX_W-1:0] gstart, send, lend;
  logic             in_base, in_short, in_long, acc;

  // Stall only a last beat, and only while the queue is full
  assign in_ready_o = !full_i || !in_i.last_sample;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && in_i.last_sample;

  // Classify the current sample against baseline window and both gates
  assign gstart   = {1'b0, cfg_i.gate_start};
  assign send     = gstart + {1'b0, cfg_i.short_gate_length};
  assign lend     = gstart + {1'b0, cfg_i.long_gate_length};
  assign in_base  = idx_q < IDX_W'(BASE);
  assign in_short = (idx_q >= gstart) && (idx_q < send);
  assign in_long  = (idx_q >= gstart) && (idx_q < lend);

  // Accumulate
  assign bsum_nx = in_base  ? bsum_q + BW'(in_i.sample) : bsum_q;
  assign ssum_nx = in_short ? ssum_q + 32'(in_i.sample) : ssum_q;
  assign lsum_nx = in_long  ? lsum_q + 32'(in_i.sample) : lsum_q;
  assign scnt_nx = in_short ? scnt_q + 16'd1 : scnt_q;
  assign lcnt_nx = in_long  ? lcnt_q + 16'd1 : lcnt_q;

  // Summary for the queue
  always_comb begin
    evt_o.time_stamp        = in_i.time_stamp;
    evt_o.chan              = in_i.chan;
    evt_o.positive_polarity = cfg_i.positive_polarity;
    evt_o.short_sum         = ssum_nx;
    evt_o.short_count       = scnt_nx;
    evt_o.long_sum          = lsum_nx;
    evt_o.long_count        = lcnt_nx;
  end
  assign bsum_o = bsum_nx;

  // Advance on each beat, clear after the last one
  always_comb begin
    idx_d  = idx_q;
    bsum_d = bsum_q;
    ssum_d = ssum_q;
    lsum_d = lsum_q;
    scnt_d = scnt_q;
    lcnt_d = lcnt_q;
    if (acc) begin
      if (in_i.last_sample) begin
        idx_d  = '0;
        bsum_d = '0;
        ssum_d = '0;
        lsum_d = '0;
        scnt_d = '0;
        lcnt_d = '0;
      end else begin
        // index holds at all ones, which lies past every gate end
        idx_d  = (&idx_q) ? idx_q : idx_q + IDX_W'(1);
        bsum_d = bsum_nx;
        ssum_d = ssum_nx;
        lsum_d = lsum_nx;
        scnt_d = scnt_nx;
        lcnt_d = lcnt_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      bsum_q <= '0;
      ssum_q <= '0;
      lsum_q <= '0;
      scnt_q <= '0;
      lcnt_q <= '0;
    end else begin
      idx_q  <= idx_d;
      bsum_q <= bsum_d;
      ssum_q <= ssum_d;
      lsum_q <= lsum_d;
      scnt_q <= scnt_d;
      lcnt_q <= lcnt_d;
    end
  end

endmodule

/* design/psd_queue.sv */
// Short register queue between front and back ends.
module psd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Step pointers with wrap, track fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/psd_back.sv */
// Back end: baseline division by reciprocal, gate charges, saturation and output register.
module psd_back #(
  parameter int BASE = 64,
  parameter int BW   = 22
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  psd_pkg::psd_evt_t evt_i,
  input  logic [BW-1:0]     bsum_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psd_pkg::psd_out_t out_o
);
  import psd_pkg::*;

  // x = 64 * baseline sum; q = floor(x / BASE) via reciprocal, off by at most one
  localparam int XW = BW + 6;
  localparam int K  = XW;
  localparam logic [XW:0] RECIP = (XW + 1)'((64'd1 << K) / 64'(BASE));

  function automatic logic [15:0] charge(input logic pol, input logic [PROD_W-1:0] nb,
                                         input logic [PROD_W-1:0] s64);
    logic [PROD_W:0] diff;
    logic [31:0]     whole;
    diff  = pol ? ({1'b0, s64} - {1'b0, nb}) : ({1'b0, nb} - {1'b0, s64});
    whole = diff[PROD_W-1:6];
    if (diff[PROD_W] || (diff == '0)) begin
      charge = '0;
    end else if (whole > 32'd65535) begin
      charge = 16'hFFFF;
    end else begin
      charge = whole[15:0];
    end
  endfunction

  logic adv;

  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  psd_evt_t        e1_q, e2_q, e3_q, e4_q;
  logic [XW-1:0]   x1_q, q1_q, x2_q, q2_q, t2_q;
  logic [B64_W-1:0] b3_q;
  logic [15:0]     lvl4_q;
  logic [PROD_W-1:0] as4_q, al4_q;
  psd_out_t        out_q;

  logic [XW-1:0]   x0, rem;
  logic [2*XW:0]   prod;
  logic [XW-1:0]   q3;
  logic [PROD_W-1:0] ss64, ls64;

  // Whole pipeline moves together whenever the output slot frees
  assign adv   = !v5_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  assign x0   = {bsum_i, 6'b0};
  assign prod = {{(XW + 1){1'b0}}, x0} * {{XW{1'b0}}, RECIP};
  assign rem  = x2_q - t2_q;
  assign q3   = (rem >= XW'(BASE)) ? q2_q + XW'(1) : q2_q;
  assign ss64 = {e4_q.short_sum, 6'b0};
  assign ls64 = {e4_q.long_sum, 6'b0};

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // estimate quotient
      e1_q <= evt_i;
      x1_q <= x0;
      q1_q <= prod[K +: XW];
      // multiply back
      e2_q <= e1_q;
      x2_q <= x1_q;
      q2_q <= q1_q;
      t2_q <= q1_q * XW'(BASE);
      // correct by one
      e3_q <= e2_q;
      b3_q <= q3[B64_W-1:0];
      // count times baseline
      e4_q   <= e3_q;
      lvl4_q <= b3_q[B64_W-1:6];
      as4_q  <= PROD_W'(e3_q.short_count) * PROD_W'(b3_q);
      al4_q  <= PROD_W'(e3_q.long_count) * PROD_W'(b3_q);
      // charges into the output register
      out_q.event_time     <= e4_q.time_stamp;
      out_q.event_channel  <= e4_q.chan;
      out_q.short_charge   <= charge(e4_q.positive_polarity, as4_q, ss64);
      out_q.long_charge    <= charge(e4_q.positive_polarity, al4_q, ls64);
      out_q.baseline_level <= lvl4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_o       = out_q;

endmodule

/* design/pulse_charge_psd_core.sv */
// Top level of the charge comparison pulse shape discrimination core.
//
// Samples enter one beat per clock; the front end does a single accumulate per beat and
// stalls only a last-sample beat, and only while its two-entry event queue is full. The
// back end is a five-stage pipeline (reciprocal multiply, multiply back, one-step
// correction, gate products, subtract and saturate) that takes one event per clock, so
// waveforms of any length, down to one sample each, sustain one sample per clock while
// the result side keeps ready high. An event's valid rises at the earliest once its
// summary has passed the queue and all five back-end stages. Configuration writes are
// always taken and should be made between waveforms; unknown register indexes are ignored.
module pulse_charge_psd_core #(
  parameter int BASE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psd_pkg::psd_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psd_pkg::psd_out_t out_o
);
  import psd_pkg::*;

  localparam int BW    = $clog2(BASE) + 16;
  localparam int QW    = BW + $bits(psd_evt_t);
  localparam int QDEPTH = 2;

  psd_cfg_t         cfg_q, cfg_d;
  psd_evt_t         f_evt, b_evt;
  logic [BW-1:0]    f_bsum, b_bsum;
  logic             push, pop, q_full, q_empty;
  logic [QW-1:0]    q_rd;

  // Register writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_POLARITY:   cfg_d.positive_polarity = cfg_data_i[0];
        REG_GATE_START: cfg_d.gate_start        = cfg_data_i;
        REG_SHORT_LEN:  cfg_d.short_gate_length = cfg_data_i;
        REG_LONG_LEN:   cfg_d.long_gate_length  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.positive_polarity <= POLARITY_RST;
      cfg_q.gate_start        <= GATE_START_RST;
      cfg_q.short_gate_length <= SHORT_LEN_RST;
      cfg_q.long_gate_length  <= LONG_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psd_front #(
    .BASE (BASE),
    .BW   (BW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .full_i     (q_full),
    .push_o     (push),
    .evt_o      (f_evt),
    .bsum_o     (f_bsum)
  );

  psd_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_bsum, f_evt}),
    .pop_i   (pop),
    .data_o  (q_rd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_bsum = q_rd[QW-1 -: BW];
  assign b_evt  = q_rd[$bits(psd_evt_t)-1:0];

  psd_back #(
    .BASE (BASE),
    .BW   (BW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .evt_i       (b_evt),
    .bsum_i      (b_bsum),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
